>>> rtl/rsenc_pkg.sv
// ----------------------------------------------------------------------------
// rsenc_pkg
// Shared constants, types and GF(256) helpers for the Reed-Solomon encoder.
// ----------------------------------------------------------------------------
package rsenc_pkg;

    localparam int unsigned MAX_ECC   = 30;
    localparam int unsigned MIN_ECC   = 2;
    localparam int unsigned CNT_W     = $clog2(MAX_ECC + 1);
    localparam int unsigned ECC_CFG_W = 5;
    localparam int unsigned ECC_RESET = 10;

    // low byte of the field polynomial 0x11d
    localparam logic [7:0] FIELD_POLY_LOW = 8'h1D;

    typedef enum logic [1:0] {
        ST_INIT,
        ST_BUILD,
        ST_RUN,
        ST_EMIT
    } rs_state_t;

    typedef struct packed {
        logic       gen_clear;
        logic       gen_step;
        logic       rem_clear;
        logic       rem_step;
        logic [7:0] fb;
        logic [7:0] root;
    } rs_ctrl_t;

    // multiply by alpha
    function automatic logic [7:0] gf_xtime(input logic [7:0] a);
        gf_xtime = {a[6:0], 1'b0} ^ (a[7] ? FIELD_POLY_LOW : 8'h00);
    endfunction

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] acc;
        logic [7:0] x;
        acc = 8'h00;
        x   = a;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) begin
                acc = acc ^ x;
            end
            x = gf_xtime(x);
        end
        gf_mul = acc;
    endfunction

    // register value saturated to the supported parity count range
    function automatic logic [CNT_W-1:0] eff_count(input logic [ECC_CFG_W-1:0] v);
        int unsigned n;
        n = int'(v);
        if (n < MIN_ECC) begin
            n = MIN_ECC;
        end
        if (n > MAX_ECC) begin
            n = MAX_ECC;
        end
        eff_count = CNT_W'(n);
    endfunction

endpackage

>>> rtl/rsenc_cell.sv
// ----------------------------------------------------------------------------
// rsenc_cell
// One tap of the encoder: a remainder byte and its generator coefficient.
// ----------------------------------------------------------------------------
module rsenc_cell (
    input  logic               aclk,
    input  logic               aresetn,
    input  rsenc_pkg::rs_ctrl_t ctrl,
    input  logic               tail,
    input  logic [7:0]         gen_left,
    input  logic [7:0]         rem_right,
    output logic [7:0]         gen_out,
    output logic [7:0]         rem_out
);
    import rsenc_pkg::*;

    logic [7:0] gen_reg;
    logic [7:0] gen_next;
    logic [7:0] rem_reg;
    logic [7:0] rem_next;
    logic [7:0] mul_a;
    logic [7:0] mul_b;
    logic [7:0] product;

    // one multiplier serves both the generator build and the division
    assign mul_a   = ctrl.gen_step ? gen_left  : ctrl.fb;
    assign mul_b   = ctrl.gen_step ? ctrl.root : gen_reg;
    assign product = gf_mul(mul_a, mul_b);

    always_comb begin
        gen_next = gen_reg;
        if (ctrl.gen_clear) begin
            gen_next = 8'h00;
        end else if (ctrl.gen_step) begin
            gen_next = gen_reg ^ product;
        end
    end

    always_comb begin
        rem_next = rem_reg;
        if (ctrl.rem_clear) begin
            rem_next = 8'h00;
        end else if (ctrl.rem_step) begin
            rem_next = (tail ? 8'h00 : rem_right) ^ product;
        end
    end

    always_ff @(posedge aclk) begin
        gen_reg <= gen_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rem_reg <= 8'h00;
        end else begin
            rem_reg <= rem_next;
        end
    end

    assign gen_out = gen_reg;
    assign rem_out = rem_reg;

endmodule

>>> rtl/reed_solomon_parity_encoder.sv
// ----------------------------------------------------------------------------
// reed_solomon_parity_encoder
// Systematic RS parity generator over GF(256), polynomial 0x11d.
// ----------------------------------------------------------------------------
//  port group   | dir | item contents
//  -------------+-----+-------------------------------------------
//  s_t*         | in  | tdata: data_byte[7:0]; tlast: last_byte
//  m_t*         | out | tdata: parity_byte[7:0]; tlast: parity_last
//  cfg_wr_*     | in  | ecc_count[4:0], write only
//
//  a data item enters the tap chain as it is accepted; after the last item
//  the n parity items leave one per cycle while m_tready is high, shifted
//  out of the chain. after reset or an ecc_count write the generator is
//  rebuilt, a clear then one root per cycle, with s_tready low.
//  reset clears the remainder and sets ecc_count to 10.
//  m_tready low holds the parity output and the input side.
// ----------------------------------------------------------------------------
module reed_solomon_parity_encoder (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [7:0]                       s_tdata,     // data_byte[7:0]
    input  logic                             s_tlast,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [7:0]                       m_tdata,     // parity_byte[7:0]
    output logic                             m_tlast,
    input  logic                             cfg_wr_en,
    input  logic [rsenc_pkg::ECC_CFG_W-1:0]  cfg_wr_data
);
    import rsenc_pkg::*;

    rs_state_t              state_reg;
    rs_state_t              state_next;
    logic [ECC_CFG_W-1:0]   ecc_count_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic [CNT_W-1:0]       cnt_next;
    logic [7:0]             root_reg;
    logic [7:0]             root_next;
    logic [CNT_W-1:0]       n_eff;
    logic [CNT_W-1:0]       last_idx;
    rs_ctrl_t               ctrl;

    logic [7:0] gen_q [MAX_ECC];
    logic [7:0] rem_q [MAX_ECC];

    assign n_eff    = eff_count(ecc_count_reg);
    assign last_idx = n_eff - CNT_W'(1);

    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        root_next      = root_reg;
        ctrl           = '0;
        ctrl.root      = root_reg;
        s_tready       = 1'b0;
        m_tvalid       = 1'b0;
        m_tlast        = 1'b0;
        case (state_reg)
            ST_INIT: begin
                ctrl.gen_clear = 1'b1;
                root_next      = 8'h01;
                cnt_next       = '0;
                state_next     = ST_BUILD;
            end
            ST_BUILD: begin
                // multiply the generator by (x + alpha^cnt)
                ctrl.gen_step = 1'b1;
                root_next     = gf_xtime(root_reg);
                cnt_next      = cnt_reg + CNT_W'(1);
                if (cnt_reg == last_idx) begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    ctrl.rem_step = 1'b1;
                    ctrl.fb       = s_tdata ^ rem_q[0];
                    if (s_tlast) begin
                        cnt_next   = '0;
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_EMIT: begin
                m_tvalid = 1'b1;
                m_tlast  = (cnt_reg == last_idx);
                if (m_tready) begin
                    // zero feedback shifts the chain toward tap 0 and clears it
                    ctrl.rem_step = 1'b1;
                    cnt_next      = cnt_reg + CNT_W'(1);
                    if (cnt_reg == last_idx) begin
                        state_next = ST_RUN;
                    end
                end
            end
            default: begin
                state_next = ST_INIT;
            end
        endcase
        if (cfg_wr_en) begin
            ctrl.rem_clear = 1'b1;
            state_next     = ST_INIT;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_INIT;
            ecc_count_reg <= ECC_CFG_W'(ECC_RESET);
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                ecc_count_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg  <= cnt_next;
        root_reg <= root_next;
    end

    for (genvar j = 0; j < MAX_ECC; j++) begin : g_cell
        logic [7:0] gen_left;
        logic [7:0] rem_right;
        logic       tail;

        if (j == 0) begin : g_first
            assign gen_left = 8'h01;
        end else begin : g_mid
            assign gen_left = gen_q[j-1];
        end

        if (j == MAX_ECC - 1) begin : g_end
            assign rem_right = 8'h00;
        end else begin : g_inner
            assign rem_right = rem_q[j+1];
        end

        assign tail = (CNT_W'(j) == last_idx);

        rsenc_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctrl      (ctrl),
            .tail      (tail),
            .gen_left  (gen_left),
            .rem_right (rem_right),
            .gen_out   (gen_q[j]),
            .rem_out   (rem_q[j])
        );
    end

    assign m_tdata = rem_q[0];

endmodule
